FILE: hdl/lpkt_pkg.sv
// lpkt_pkg: shared widths, operation and status codes, and the controller/datapath
// command and status structs of the linear probe key table
// no dependencies
`default_nettype none

package lpkt_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int ST_W     = 2;
   localparam int SLOT_W   = 10;
   localparam int TS_W     = 11;
   localparam int DIV_BITS = 4;

   localparam logic [TS_W-1:0] TS_RST = 11'd1021;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic clear;
      logic start;
      logic div_step;
      logic probe_init;
      logic probe_run;
      logic record_trivial;
      logic record_probe;
      logic load_rsp;
   } lpkt_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic trivial;
      logic div_last;
      logic hit;
      logic miss;
      logic rsp_free;
   } lpkt_stat_type;

endpackage

`default_nettype wire

FILE: hdl/lpkt_if.sv
// lpkt channel interfaces: request, response and table size write channels
// depends on lpkt_pkg
`default_nettype none

interface lpkt_req_if
   import lpkt_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [KEY_W-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

interface lpkt_rsp_if
   import lpkt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ST_W-1:0]   status;
   logic [KEY_W-1:0]  result_key;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output status, output result_key, output slot, input ready);
   modport sink   (input valid, input status, input result_key, input slot, output ready);
endinterface

interface lpkt_csr_if
   import lpkt_pkg::*;
   ;
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

`default_nettype wire

FILE: hdl/linear_probe_key_table_top.sv
// Linear probe key table. After reset the block clears every slot of the slot memory and
// accepts no request until done; table size writes are taken at any time. An insert, lookup
// or delete then goes through these steps: the home slot (key mod table size, 4 bits per
// cycle), the start of the walk, a registered read of each slot probed from the slot memory
// (one read port), a compare of each read, and the load of the response, which waits until
// the previous response is taken. Lookup or delete of key 0, an unused op and insert with the
// key counter exhausted skip the home slot and the walk and go straight to the response load.
// One request is worked at a time; a waiting response does not block acceptance.
// depends on lpkt_pkg, lpkt_if, lpkt_ctrl, lpkt_dp
`default_nettype none

module linear_probe_key_table_top
   import lpkt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpkt_req_if.sink   req_ch,
   lpkt_rsp_if.source rsp_ch,
   lpkt_csr_if.sink   csr_ch
);

   lpkt_cmd_type  cmd;
   lpkt_stat_type stat;

   assign csr_ch.ready = 1'b1;

   lpkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpkt_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_ch.op),
      .req_key        (req_ch.key),
      .csr_we         (csr_ch.valid),
      .csr_table_size (csr_ch.table_size),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_status     (rsp_ch.status),
      .rsp_result_key (rsp_ch.result_key),
      .rsp_slot       (rsp_ch.slot)
   );

endmodule

`default_nettype wire

FILE: hdl/lpkt_mod.sv
// lpkt_mod: iterative key mod table size, DIV_BITS quotient bits per step
// depends on lpkt_pkg
`default_nettype none

module lpkt_mod
   import lpkt_pkg::*;
#(
   parameter int AW = 11
) (
   input  wire logic             clock,
   input  wire logic             start,
   input  wire logic             step,
   input  wire logic [KEY_W-1:0] dividend,
   input  wire logic [AW-1:0]    divisor,
   output logic      [AW-1:0]    rem,
   output logic                  last
);

   localparam int STEPS = KEY_W / DIV_BITS;
   localparam int CNT_W = $clog2(STEPS);

   logic [AW-1:0]    rem_ff, rem_in;
   logic [KEY_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW:0]      trial;

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      trial  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {rem_in, sh_in[KEY_W-1]};
         sh_in = {sh_in[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[AW-1:0];
      end
      cnt_in = cnt_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         sh_ff  <= dividend;
         cnt_ff <= '0;
      end else if (step) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rem  = rem_ff;
   assign last = (cnt_ff == CNT_W'(STEPS - 1));

endmodule

`default_nettype wire

FILE: hdl/lpkt_ctrl.sv
// lpkt_ctrl: sequencing state machine for clear, home slot, probe and response
// depends on lpkt_pkg
`default_nettype none

module lpkt_ctrl
   import lpkt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire lpkt_stat_type stat,
   output lpkt_cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_PSTART = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.trivial) begin
               cmd.record_trivial = 1'b1;
               state_in           = S_FINISH;
            end else begin
               cmd.div_step = 1'b1;
               if (stat.div_last) begin
                  state_in = S_PSTART;
               end
            end
         end
         S_PSTART: begin
            cmd.probe_init = 1'b1;
            state_in       = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe_run = 1'b1;
            if (stat.hit || stat.miss) begin
               cmd.record_probe = 1'b1;
               state_in         = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/lpkt_dp.sv
// lpkt_dp: slot memory, key counter, table size, probe walk and response register
// depends on lpkt_pkg and lpkt_mod
`default_nettype none

module lpkt_dp
   import lpkt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lpkt_cmd_type      cmd,
   output lpkt_stat_type          stat,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic              csr_we,
   input  wire logic [TS_W-1:0]   csr_table_size,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic      [ST_W-1:0]   rsp_status,
   output logic      [KEY_W-1:0]  rsp_result_key,
   output logic      [SLOT_W-1:0] rsp_slot
);

   localparam int IW      = $clog2(SLOTS);
   localparam int SZW     = $clog2(SLOTS + 1);
   localparam int AW      = (SZW < TS_W) ? SZW : TS_W;
   localparam int XW      = (SZW > TS_W) ? SZW : TS_W;
   localparam int ACT_RST = (int'(TS_RST) > SLOTS) ? SLOTS : int'(TS_RST);

   logic [KEY_W-1:0] mem [SLOTS];

   logic [AW-1:0]     active_ff, active_in;
   logic [XW-1:0]     ts_x;
   logic [OP_W-1:0]   op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_cnt_ff;
   logic [KEY_W-1:0]  next_key;
   logic [IW-1:0]     idx_ff;
   logic [IW:0]       idx_inc;
   logic [AW-1:0]     iss_cnt_ff;
   logic [AW-1:0]     cmp_cnt_ff;
   logic              rd_valid_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic [KEY_W-1:0]  rdata_ff;
   logic              found_ff;
   logic [IW-1:0]     slot_ff;
   logic [IW-1:0]     clr_addr_ff;
   logic              issue;
   logic [KEY_W-1:0]  wanted;
   logic              match;
   logic              is_insert;
   logic              is_find;
   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   logic [KEY_W-1:0]  mem_wdata;
   logic [AW-1:0]     home_rem;
   logic              div_last;
   logic [KEY_W-1:0]  home_key;
   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [ST_W-1:0]   res_status;
   logic [KEY_W-1:0]  res_key;
   logic [SLOT_W-1:0] res_slot;

   // table size clamped to 1..SLOTS at write time
   always_comb begin
      ts_x = XW'(csr_table_size);
      if (csr_table_size == '0) begin
         active_in = AW'(1);
      end else if (ts_x > XW'(SLOTS)) begin
         active_in = AW'(SLOTS);
      end else begin
         active_in = AW'(ts_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= AW'(ACT_RST);
      end else if (csr_we) begin
         active_ff <= active_in;
      end
   end

   assign next_key  = key_cnt_ff + KEY_W'(1);
   assign home_key  = (req_op == OP_INSERT) ? next_key : req_key;
   assign is_insert = (op_ff == OP_INSERT);
   assign is_find   = (op_ff == OP_LOOKUP) || (op_ff == OP_DELETE);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
   end

   lpkt_mod #(
      .AW (AW)
   ) u_mod (
      .clock    (clock),
      .start    (cmd.start),
      .step     (cmd.div_step),
      .dividend (home_key),
      .divisor  (active_ff),
      .rem      (home_rem),
      .last     (div_last)
   );

   // probe walk: issue one read per cycle, compare each read in the next cycle
   assign wanted  = is_insert ? '0 : key_ff;
   assign match   = rd_valid_ff && (rdata_ff == wanted);
   assign issue   = cmd.probe_run && (iss_cnt_ff != active_ff);
   assign idx_inc = {1'b0, idx_ff} + (IW+1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.probe_init) begin
         idx_ff      <= IW'(home_rem);
         iss_cnt_ff  <= '0;
         cmp_cnt_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         rd_idx_ff   <= idx_ff;
         if (issue) begin
            iss_cnt_ff <= iss_cnt_ff + AW'(1);
            if (idx_inc == (IW+1)'(active_ff)) begin
               idx_ff <= '0;
            end else begin
               idx_ff <= idx_inc[IW-1:0];
            end
         end
         if (rd_valid_ff) begin
            cmp_cnt_ff <= cmp_cnt_ff + AW'(1);
         end
      end
   end

   // slot memory with clearing pass after reset
   assign mem_we    = cmd.clear || (cmd.record_probe && match && (is_insert || op_ff == OP_DELETE));
   assign mem_waddr = cmd.clear ? clr_addr_ff : rd_idx_ff;
   assign mem_wdata = (cmd.clear || !is_insert) ? '0 : next_key;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cnt_ff <= '0;
      end else if (cmd.record_probe && match && is_insert) begin
         key_cnt_ff <= next_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.record_trivial) begin
         found_ff <= 1'b0;
      end else if (cmd.record_probe) begin
         found_ff <= match;
         slot_ff  <= rd_idx_ff;
      end
   end

   // result fields
   always_comb begin
      res_status = ST_NOT_FOUND;
      res_key    = key_ff;
      res_slot   = '0;
      case (op_ff)
         OP_INSERT: begin
            if (found_ff) begin
               res_status = ST_OK;
               res_key    = key_cnt_ff;
               res_slot   = SLOT_W'(slot_ff);
            end else begin
               res_status = ST_FULL;
               res_key    = '0;
            end
         end
         OP_LOOKUP, OP_DELETE: begin
            if (found_ff) begin
               res_status = ST_OK;
               res_slot   = SLOT_W'(slot_ff);
            end
         end
         default: begin
            res_status = ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status;
         rsp_key_ff    <= res_key;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_key = rsp_key_ff;
   assign rsp_slot       = rsp_slot_ff;

   always_comb begin
      stat            = '0;
      stat.clear_last = (clr_addr_ff == IW'(SLOTS - 1));
      stat.trivial    = (is_insert && (key_cnt_ff == '1))
                     || (is_find && (key_ff == '0))
                     || (!is_insert && !is_find);
      stat.div_last   = div_last;
      stat.hit        = match;
      stat.miss       = rd_valid_ff && !match && (cmp_cnt_ff == active_ff - AW'(1));
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for linear_probe_key_table_top, random and directed insert/lookup/delete
// traffic checked against a slot-accurate table predictor kept in a small scoreboard class
// depends on lpkt_pkg, lpkt_if and linear_probe_key_table_top
`default_nettype none

module tb
   import lpkt_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS        = 1024;
   localparam int unsigned CLK_PERIOD   = 20;
   localparam int unsigned LIMIT_CYCLES = 20_000_000;
   localparam int unsigned HOLD_LEN     = 300;
   localparam int unsigned N_PHASES     = 8;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [ST_W-1:0]   status;
      logic [KEY_W-1:0]  result_key;
      logic [SLOT_W-1:0] slot;
   } table_answer_type;

   class key_table_scoreboard;
      logic [KEY_W-1:0] slot_key [SLOTS];
      logic [KEY_W-1:0] key_count;
      logic [TS_W-1:0]  table_size_raw;
      table_answer_type pending [$];
      int unsigned      errors;

      function new();
         foreach (slot_key[i]) slot_key[i] = '0;
         key_count      = '0;
         table_size_raw = TS_RST;
         errors         = 0;
      endfunction

      function int unsigned active_slots();
         if (table_size_raw == '0) return 1;
         if (table_size_raw > SLOTS) return SLOTS;
         return table_size_raw;
      endfunction

      // linear walk over every slot in use, starting at the home slot
      function bit find(logic [KEY_W-1:0] home, logic [KEY_W-1:0] wanted,
                        output int unsigned where);
         int unsigned lim;
         int unsigned idx;
         lim   = active_slots();
         idx   = home % lim;
         where = 0;
         for (int unsigned n = 0; n < lim; n++) begin
            if (slot_key[idx] == wanted) begin
               where = idx;
               return 1'b1;
            end
            idx = (idx + 1 == lim) ? 0 : idx + 1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
         table_answer_type ans;
         int unsigned      where;
         ans = '{status: ST_NOT_FOUND, result_key: key, slot: '0};
         if (op == OP_INSERT) begin
            ans.status     = ST_FULL;
            ans.result_key = '0;
            if (key_count != '1 && find(key_count + 1'b1, '0, where)) begin
               key_count       = key_count + 1'b1;
               slot_key[where] = key_count;
               ans = '{status: ST_OK, result_key: key_count, slot: where[SLOT_W-1:0]};
            end
         end else if ((op == OP_LOOKUP || op == OP_DELETE) && key != '0
                      && find(key, key, where)) begin
            ans.status = ST_OK;
            ans.slot   = where[SLOT_W-1:0];
            if (op == OP_DELETE) slot_key[where] = '0;
         end
         pending.push_back(ans);
      endfunction

      function void check_response(logic [ST_W-1:0] status, logic [KEY_W-1:0] result_key,
                                   logic [SLOT_W-1:0] slot);
         table_answer_type want;
         if (pending.size() == 0) begin
            errors++;
            $error("response with no transaction pending: status %0d key %0h slot %0d",
                   status, result_key, slot);
            return;
         end
         want = pending.pop_front();
         if (status !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, status);
         end
         if (result_key !== want.result_key) begin
            errors++;
            $error("result_key: expected %0h, actual %0h", want.result_key, result_key);
         end
         if (slot !== want.slot) begin
            errors++;
            $error("slot: expected %0d, actual %0d", want.slot, slot);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lpkt_req_if req_ch ();
   lpkt_rsp_if rsp_ch ();
   lpkt_csr_if csr_ch ();

   linear_probe_key_table_top #(.SLOTS(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   key_table_scoreboard sb = new();

   int unsigned req_idle_pct = 17;
   int unsigned rsp_idle_pct = 80;
   int unsigned hold_asked   = 0;

   int unsigned phase_size  [N_PHASES] = '{2, 7, 2047, 13, 1024, 1, 31, 64};
   int unsigned phase_items [N_PHASES] = '{150, 350, 250, 350, 100, 60, 350, 318};

   always #(CLK_PERIOD / 2) clock = ~clock;

   // response side: random stalls plus an occasional long hold-off
   initial begin
      int unsigned hold_seen;
      int unsigned hold_left;
      hold_seen    = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_LEN;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         sb.check_response(rsp_ch.status, rsp_ch.result_key, rsp_ch.slot);
      end
   end

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.key   <= key;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(op, key);
      @(negedge clock);
   endtask

   task automatic write_table_size(input logic [TS_W-1:0] value);
      wait_idle();
      csr_ch.valid      <= 1'b1;
      csr_ch.table_size <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.table_size_raw = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // mostly hits on stored keys and fresh inserts, the rest misses and odd codes
   task automatic send_random();
      int unsigned      pick;
      int unsigned      lim;
      int unsigned      start;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(99);
      k    = $urandom();
      if (pick < 35) begin
         send_item(OP_INSERT, k);
      end else if (pick < 85) begin
         lim   = sb.active_slots();
         start = $urandom_range(lim - 1);
         k     = '0;
         for (int unsigned n = 0; n < lim && k == '0; n++) k = sb.slot_key[(start + n) % lim];
         send_item((pick < 65) ? OP_LOOKUP : OP_DELETE, k);
      end else if (pick < 90) begin
         send_item($urandom_range(1) ? OP_LOOKUP : OP_DELETE, k);
      end else if (pick < 94) begin
         send_item(OP_UNUSED, k);
      end else if (pick < 97) begin
         send_item($urandom_range(1) ? OP_LOOKUP : OP_DELETE, '0);
      end else begin
         send_item($urandom_range(1) ? OP_LOOKUP : OP_DELETE,
                   $urandom_range(sb.key_count + 2, 1));
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_INSERT;
      req_ch.key        = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.table_size = TS_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, then basic hits, misses, key zero and the unused code
      send_item(OP_LOOKUP, 32'd1);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_INSERT, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 32'h5A5A_A5A5);
      send_item(OP_LOOKUP, 32'd2);
      send_item(OP_LOOKUP, 32'd0);
      send_item(OP_DELETE, 32'd0);
      send_item(OP_LOOKUP, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'd0);
      send_item(OP_DELETE, 32'd2);
      send_item(OP_LOOKUP, 32'd2);
      send_item(OP_DELETE, 32'd2);
      send_item(OP_INSERT, 32'd0);
      send_item(OP_LOOKUP, 32'd3);

      // size zero acts as one slot: full table, keys stranded beyond the size
      write_table_size('0);
      send_item(OP_INSERT, 32'd0);
      send_item(OP_INSERT, 32'd0);
      send_item(OP_LOOKUP, 32'd5);
      send_item(OP_LOOKUP, 32'd1);
      send_item(OP_DELETE, 32'd5);
      send_item(OP_INSERT, 32'd0);

      for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
         if (ph == 3) begin
            req_idle_pct = 80;
            rsp_idle_pct = 17;
         end
         if (ph == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_table_size(TS_W'(phase_size[ph]));
         for (int unsigned i = 0; i < phase_items[ph]; i++) begin
            if ((ph == 1 || ph == 6) && i == 100) hold_asked++;
            if (ph == 1 && i == 200) wait_idle();
            send_random();
         end
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
